/* rtl/core/mkd_pkg.sv */
// ----------------------------------------------------------------------------
// mkd_pkg
// Shared types and constants for the Morse key decoder: payload widths,
// register indexes, result beat layout and the a-z / 0-9 code table.
// ----------------------------------------------------------------------------
package mkd_pkg;

  // Payload widths
  localparam int TICK_W   = 16;
  localparam int ASCII_W  = 7;
  localparam int LENGTH_W = 5;
  localparam int CFG_IDX_W = 2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_DASH_THRESHOLD   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS_TICKS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CHAR_GAP_TICKS   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPACE_GAP_TICKS  = 2'd3;

  // Register reset values
  localparam logic [TICK_W-1:0] DASH_THRESHOLD_RST   = 16'd20;
  localparam logic [TICK_W-1:0] LONG_PRESS_TICKS_RST = 16'd100;
  localparam logic [TICK_W-1:0] CHAR_GAP_TICKS_RST   = 16'd40;
  localparam logic [TICK_W-1:0] SPACE_GAP_TICKS_RST  = 16'd120;

  // Release counter stops here; this value lies beyond every gap
  localparam logic [TICK_W-1:0] SAT_TICKS = 16'hFFFF;

  localparam logic [ASCII_W-1:0] ASCII_SPACE = 7'd32;
  localparam logic [ASCII_W-1:0] ASCII_NONE  = 7'd0;

  // Code table: 26 letters then 10 digits
  localparam int TABLE_SIZE  = 36;
  localparam int LETTER_COUNT = 26;
  localparam int CODE_MAX_LEN = 5;

  // Bit i holds mark i of the code, 1 = dash
  localparam logic [CODE_MAX_LEN-1:0] MORSE_PAT [TABLE_SIZE] = '{
    5'b00010, 5'b00001, 5'b00101, 5'b00001, 5'b00000, 5'b00100, // a-f
    5'b00011, 5'b00000, 5'b00000, 5'b01110, 5'b00101, 5'b00010, // g-l
    5'b00011, 5'b00001, 5'b00111, 5'b00110, 5'b01011, 5'b00010, // m-r
    5'b00000, 5'b00001, 5'b00100, 5'b01000, 5'b00110, 5'b01001, // s-x
    5'b01101, 5'b00011,                                         // y-z
    5'b11111, 5'b11110, 5'b11100, 5'b11000, 5'b10000,           // 0-4
    5'b00000, 5'b00001, 5'b00011, 5'b00111, 5'b01111            // 5-9
  };

  // Number of marks in each code
  localparam logic [2:0] MORSE_LEN [TABLE_SIZE] = '{
    3'd2, 3'd4, 3'd4, 3'd3, 3'd1, 3'd4,
    3'd3, 3'd4, 3'd2, 3'd4, 3'd3, 3'd4,
    3'd2, 3'd2, 3'd3, 3'd4, 3'd4, 3'd3,
    3'd3, 3'd1, 3'd3, 3'd4, 3'd3, 3'd4,
    3'd4, 3'd4,
    3'd5, 3'd5, 3'd5, 3'd5, 3'd5,
    3'd5, 3'd5, 3'd5, 3'd5, 3'd5
  };

  // One result beat
  typedef struct packed {
    logic               char_valid;
    logic [ASCII_W-1:0] char_code;
    logic               space_added;
    logic               deleted;
    logic               not_found;
    logic               finished;
    logic               leave_mode;
    logic [LENGTH_W-1:0] text_length;
    logic               text_wrapped;
    logic               text_updated;
  } result_t;

endpackage

/* rtl/core/mkd_if.sv */
// ----------------------------------------------------------------------------
// mkd_if
// Valid/ready channels of the Morse key decoder: key tick beats in,
// result beats out.
// ----------------------------------------------------------------------------

// Key tick channel
interface mkd_key_if;
  logic                       valid;
  logic                       ready;
  logic                       key_level;
  logic [mkd_pkg::TICK_W-1:0] press_ticks;
  logic                       delete_short;
  logic                       delete_long;

  modport source (
    output valid, key_level, press_ticks, delete_short, delete_long,
    input  ready
  );
  modport sink (
    input  valid, key_level, press_ticks, delete_short, delete_long,
    output ready
  );
endinterface

// Result channel
interface mkd_res_if;
  logic                         valid;
  logic                         ready;
  logic                         char_valid;
  logic [mkd_pkg::ASCII_W-1:0]  char_code;
  logic                         space_added;
  logic                         deleted;
  logic                         not_found;
  logic                         finished;
  logic                         leave_mode;
  logic [mkd_pkg::LENGTH_W-1:0] text_length;
  logic                         text_wrapped;
  logic                         text_updated;

  modport source (
    output valid, char_valid, char_code, space_added, deleted, not_found,
           finished, leave_mode, text_length, text_wrapped, text_updated,
    input  ready
  );
  modport sink (
    input  valid, char_valid, char_code, space_added, deleted, not_found,
           finished, leave_mode, text_length, text_wrapped, text_updated,
    output ready
  );
endinterface

/* rtl/core/mkd_match.sv */
// ----------------------------------------------------------------------------
// mkd_match
// Matches the collected marks against the 36-entry Morse table in parallel
// and returns the ASCII code of the entry that matches.
// ----------------------------------------------------------------------------
module mkd_match #(
  parameter int MARK_DEPTH = 8,
  localparam int COUNT_W = $clog2(MARK_DEPTH)
) (
  input  logic [MARK_DEPTH-1:0]        marks,
  input  logic [COUNT_W-1:0]           mark_count,
  output logic                         hit,
  output logic [mkd_pkg::ASCII_W-1:0]  code
);

  logic [mkd_pkg::TABLE_SIZE-1:0] entry_hit;

  // One comparator per table entry; only the first len marks take part
  always_comb begin
    logic [mkd_pkg::CODE_MAX_LEN-1:0] used;
    logic [mkd_pkg::ASCII_W-1:0]      ascii;
    code = mkd_pkg::ASCII_NONE;
    for (int i = 0; i < mkd_pkg::TABLE_SIZE; i++) begin
      for (int j = 0; j < mkd_pkg::CODE_MAX_LEN; j++) begin
        used[j] = (j < int'(mkd_pkg::MORSE_LEN[i]));
      end
      entry_hit[i] = (mark_count == COUNT_W'(mkd_pkg::MORSE_LEN[i])) &&
                     ((marks[mkd_pkg::CODE_MAX_LEN-1:0] & used) ==
                      mkd_pkg::MORSE_PAT[i]);
      if (i < mkd_pkg::LETTER_COUNT) begin
        ascii = mkd_pkg::ASCII_W'(97 + i);
      end else begin
        ascii = mkd_pkg::ASCII_W'(48 + i - mkd_pkg::LETTER_COUNT);
      end
      // codes are unique, so at most one entry contributes
      code = code | (entry_hit[i] ? ascii : mkd_pkg::ASCII_NONE);
    end
    hit = |entry_hit;
  end

endmodule

/* rtl/core/morse_key_decoder_top.sv */
// ----------------------------------------------------------------------------
// morse_key_decoder_top
// Morse key decoder. Takes one key tick beat per cycle while key_in.ready
// is high and returns exactly one result beat per tick, in the cycle after
// acceptance. The whole tick is handled by the mark/gap logic and the
// parallel table matcher between the input port and the result register,
// so the block sustains one beat per clock while results are taken; the
// result register decouples the two channels and key_in.ready only drops
// while a held result is not yet taken. Dot and dash marks are recorded
// when the release count is one and decoded at char_gap_ticks of release;
// a space is appended at space_gap_ticks. Short delete removes a character,
// long delete raises leave_mode. No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
module morse_key_decoder_top #(
  parameter int MARK_DEPTH = 8,
  parameter int TEXT_DEPTH = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  mkd_key_if.sink                       key_in,
  mkd_res_if.source                     res_out,
  input  logic                          cfg_we,
  input  logic [mkd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [mkd_pkg::TICK_W-1:0]    cfg_data
);

  localparam int COUNT_W = $clog2(MARK_DEPTH);
  localparam int POS_W   = $clog2(TEXT_DEPTH);

  // Configuration registers
  logic [mkd_pkg::TICK_W-1:0] dash_threshold;
  logic [mkd_pkg::TICK_W-1:0] long_press_ticks;
  logic [mkd_pkg::TICK_W-1:0] char_gap_ticks;
  logic [mkd_pkg::TICK_W-1:0] space_gap_ticks;

  // Decoder state
  logic [MARK_DEPTH-1:0]      marks;
  logic [MARK_DEPTH-1:0]      marks_next;
  logic [COUNT_W-1:0]         mark_count;
  logic [COUNT_W-1:0]         mark_count_next;
  logic [mkd_pkg::TICK_W-1:0] release_ticks;
  logic [mkd_pkg::TICK_W-1:0] release_ticks_next;
  logic [POS_W-1:0]           text_position;
  logic [POS_W-1:0]           text_position_next;

  // Result register
  logic              res_valid;
  mkd_pkg::result_t  res;
  mkd_pkg::result_t  res_next;

  logic accept;
  logic match_hit;
  logic [mkd_pkg::ASCII_W-1:0] match_code;

  assign key_in.ready = !res_valid || res_out.ready;
  assign accept       = key_in.valid && key_in.ready;

  // Table matcher
  mkd_match #(
    .MARK_DEPTH (MARK_DEPTH)
  ) u_match (
    .marks      (marks),
    .mark_count (mark_count),
    .hit        (match_hit),
    .code       (match_code)
  );

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      dash_threshold   <= mkd_pkg::DASH_THRESHOLD_RST;
      long_press_ticks <= mkd_pkg::LONG_PRESS_TICKS_RST;
      char_gap_ticks   <= mkd_pkg::CHAR_GAP_TICKS_RST;
      space_gap_ticks  <= mkd_pkg::SPACE_GAP_TICKS_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        mkd_pkg::REG_DASH_THRESHOLD:   dash_threshold   <= cfg_data;
        mkd_pkg::REG_LONG_PRESS_TICKS: long_press_ticks <= cfg_data;
        mkd_pkg::REG_CHAR_GAP_TICKS:   char_gap_ticks   <= cfg_data;
        mkd_pkg::REG_SPACE_GAP_TICKS:  space_gap_ticks  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Per-tick update of marks, counters, text position and result
  always_comb begin
    logic             live;
    logic             do_decode;
    logic             do_space;
    logic             do_append;
    logic             skip_delete;
    logic [POS_W:0]   pos_inc;
    logic [POS_W-1:0] pos_mid;
    logic             wrap;
    logic [POS_W+4:0] pos_wide;

    marks_next         = marks;
    mark_count_next    = mark_count;
    release_ticks_next = release_ticks;
    pos_mid            = text_position;
    res_next           = '0;
    skip_delete        = 1'b0;
    do_decode          = 1'b0;
    do_space           = 1'b0;
    live               = (release_ticks != mkd_pkg::SAT_TICKS);

    if (!key_in.key_level) begin
      // key held
      release_ticks_next = '0;
      if (key_in.press_ticks == long_press_ticks) begin
        res_next.finished = 1'b1;
        pos_mid           = '0;
        skip_delete       = 1'b1;
      end
    end else begin
      if (release_ticks == 16'd1) begin
        // release count of one: record a mark
        if (key_in.press_ticks != '0 && key_in.press_ticks < long_press_ticks) begin
          marks_next[mark_count] = (key_in.press_ticks >= dash_threshold);
          if (mark_count == COUNT_W'(MARK_DEPTH - 1)) begin
            mark_count_next = '0;
          end else begin
            mark_count_next = mark_count + 1'b1;
          end
        end
      end else if (live && release_ticks == char_gap_ticks && mark_count != '0) begin
        do_decode       = 1'b1;
        mark_count_next = '0;
        skip_delete     = 1'b1;
      end else if (live && release_ticks == space_gap_ticks) begin
        do_space = 1'b1;
      end
      if (!do_decode && live) begin
        release_ticks_next = release_ticks + 1'b1;
      end
    end

    // Append a letter, digit or space
    do_append = (do_decode && match_hit) || do_space;
    pos_inc   = {1'b0, pos_mid} + 1'b1;
    wrap      = (pos_inc == (POS_W + 1)'(TEXT_DEPTH));
    if (do_append) begin
      pos_mid               = wrap ? '0 : pos_inc[POS_W-1:0];
      res_next.text_wrapped = wrap;
      res_next.text_updated = 1'b1;
    end
    res_next.char_valid  = do_decode && match_hit;
    res_next.not_found   = do_decode && !match_hit;
    res_next.space_added = do_space;
    if (do_decode && match_hit) begin
      res_next.char_code = match_code;
    end else if (do_space) begin
      res_next.char_code = mkd_pkg::ASCII_SPACE;
    end

    // Delete key
    if (!skip_delete) begin
      if (key_in.delete_short) begin
        if (pos_mid != '0) begin
          pos_mid               = pos_mid - 1'b1;
          res_next.deleted      = 1'b1;
          res_next.text_updated = 1'b1;
        end
      end else if (key_in.delete_long) begin
        res_next.leave_mode = 1'b1;
      end
    end

    text_position_next   = pos_mid;
    pos_wide             = {5'b0, pos_mid};
    res_next.text_length = pos_wide[mkd_pkg::LENGTH_W-1:0];
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      mark_count    <= '0;
      release_ticks <= '0;
      text_position <= '0;
    end else if (accept) begin
      mark_count    <= mark_count_next;
      release_ticks <= release_ticks_next;
      text_position <= text_position_next;
    end
  end

  // Mark store holds payload only
  always_ff @(posedge clk) begin
    if (accept) begin
      marks <= marks_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (accept) begin
      res_valid <= 1'b1;
    end else if (res_out.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res <= res_next;
    end
  end

  assign res_out.valid        = res_valid;
  assign res_out.char_valid   = res.char_valid;
  assign res_out.char_code    = res.char_code;
  assign res_out.space_added  = res.space_added;
  assign res_out.deleted      = res.deleted;
  assign res_out.not_found    = res.not_found;
  assign res_out.finished     = res.finished;
  assign res_out.leave_mode   = res.leave_mode;
  assign res_out.text_length  = res.text_length;
  assign res_out.text_wrapped = res.text_wrapped;
  assign res_out.text_updated = res.text_updated;

`ifndef NO_ASSERTIONS
  // A held key always restarts the release count
  a_release_clear: assert property (@(posedge clk) disable iff (rst)
    (accept && !key_in.key_level) |=> (release_ticks == '0))
    else $error("release counter not cleared by held key");

  // Mark count stays inside the buffer
  a_mark_count: assert property (@(posedge clk) disable iff (rst)
    mark_count <= COUNT_W'(MARK_DEPTH - 1))
    else $error("mark count beyond buffer");

  // Text position stays inside the text
  a_text_pos: assert property (@(posedge clk) disable iff (rst)
    (POS_W + 1)'(text_position) < (POS_W + 1)'(TEXT_DEPTH))
    else $error("text position beyond text depth");

  // At most one of the main events per result beat
  a_one_event: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> $onehot0({res.char_valid, res.space_added, res.not_found,
                            res.finished}))
    else $error("conflicting events in one result");
`endif

endmodule
